// ===== hdl/pip_pkg.sv =====
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = 7;
	localparam int COORD_W      = 32;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * COORD_W;
	localparam int APB_DW       = 32;
	localparam int APB_AW       = 3;

	localparam logic [VCNT_W-1:0] MAX_COUNT = VCNT_W'(MAX_VERTICES);
	localparam logic [VCNT_W-1:0] MIN_COUNT = VCNT_W'(3);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_VERTEX_COUNT = 1'b0;

endpackage

// ===== hdl/point_in_polygon_test.sv =====
// Point-in-polygon test by crossing number.
// Input channel (in_valid/in_ready) carries one word: operation, vertex_index,
// coord_x, coord_y. A load word writes one vertex into the store.
// A query word starts a walk over all edges of the polygon; the block is not
// ready again until the result has been handed to the output register.
// Output channel (out_valid/out_ready) carries inside_res and crossing_count,
// one word per query, none per load.
// A query first reads the last vertex, then walks n = vertex_count edges
// (clamped to the store depth). Each edge takes a difference step and a
// magnitude step; an edge whose y span straddles the point also takes two
// passes through the single 32x32 multiplier and a compare step. With fewer
// than three vertices a query skips the walk and finishes with a crossing
// count of zero.
// The output register frees the walk from the receiver: a stalled out_ready
// only holds the block once a second result is finished. The user writes
// vertex_count over the APB port only while the block is idle; the block
// does not enforce it. Reset clears vertex_count and the control state;
// the vertex store keeps no reset and must be loaded before a query reads it.
module point_in_polygon_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [pip_pkg::VIDX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]  coord_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                inside_res,
	output logic [pip_pkg::VCNT_W-1:0]          crossing_count,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pip_pkg::APB_AW-1:0]          paddr,
	input  logic [pip_pkg::APB_DW-1:0]          pwdata,
	output logic [pip_pkg::APB_DW-1:0]          prdata,
	output logic                                pready
);

	typedef enum logic [2:0] {
		S_IDLE, S_LAST, S_EDGE, S_ABS, S_MULA, S_MULB, S_CMP, S_DONE
	} state_t;

	state_t state_q;

	logic [pip_pkg::VCNT_W-1:0]          vcount_q;
	logic [pip_pkg::VCNT_W-1:0]          count_q;
	logic [pip_pkg::VIDX_W-1:0]          rd_idx_q;
	logic                                out_valid_q;
	logic                                inside_q;
	logic [pip_pkg::VCNT_W-1:0]          crossing_q;

	logic signed [pip_pkg::COORD_W-1:0]  mem_x [pip_pkg::MAX_VERTICES];
	logic signed [pip_pkg::COORD_W-1:0]  mem_y [pip_pkg::MAX_VERTICES];
	logic signed [pip_pkg::COORD_W-1:0]  rdx_q, rdy_q;
	logic [pip_pkg::VIDX_W-1:0]          raddr;

	logic signed [pip_pkg::COORD_W-1:0]  px_q, py_q, xj_q, yj_q;
	logic [pip_pkg::VIDX_W-1:0]          last_q;
	logic                                is_last_q;
	logic                                straddle_q;
	logic [pip_pkg::DIFF_W-1:0]          dy_q, dx_q, t_q, rx_q;
	logic [pip_pkg::COORD_W-1:0]         mag_a1_q, mag_a2_q, mag_b1_q, mag_b2_q;
	logic                                neg_a_q, neg_b_q;
	logic [pip_pkg::PROD_W-1:0]          ma_q, mb_q;

	logic [pip_pkg::VCNT_W-1:0]          nclamp;
	logic [pip_pkg::VIDX_W-1:0]          last_idx;
	logic                                in_acc, load_acc, query_acc;
	logic                                cfg_wr;
	logic [pip_pkg::COORD_W-1:0]         mul_a, mul_b;
	logic [pip_pkg::PROD_W-1:0]          mul_p;
	logic                                na, nb, lt;

	function automatic logic [pip_pkg::COORD_W-1:0] mag33(
		input logic [pip_pkg::DIFF_W-1:0] v
	);
		logic [pip_pkg::DIFF_W-1:0] m;
		m = v[pip_pkg::DIFF_W-1] ? (~v + pip_pkg::DIFF_W'(1)) : v;
		return m[pip_pkg::COORD_W-1:0];
	endfunction

	function automatic logic [pip_pkg::DIFF_W-1:0] sub33(
		input logic signed [pip_pkg::COORD_W-1:0] a,
		input logic signed [pip_pkg::COORD_W-1:0] b
	);
		return {a[pip_pkg::COORD_W-1], a} - {b[pip_pkg::COORD_W-1], b};
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign load_acc  = in_acc && (operation == pip_pkg::OP_LOAD);
	assign query_acc = in_acc && (operation == pip_pkg::OP_QUERY);

	assign nclamp   = (vcount_q > pip_pkg::MAX_COUNT) ? pip_pkg::MAX_COUNT : vcount_q;
	assign last_idx = pip_pkg::VIDX_W'(nclamp - pip_pkg::VCNT_W'(1));
	assign raddr    = (state_q == S_IDLE) ? last_idx : rd_idx_q;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == pip_pkg::REG_VERTEX_COUNT);
	assign prdata = (paddr[2] == pip_pkg::REG_VERTEX_COUNT) ?
		{{(pip_pkg::APB_DW - pip_pkg::VCNT_W){1'b0}}, vcount_q} : '0;

	// shared multiplier
	assign mul_a = (state_q == S_MULA) ? mag_a1_q : mag_b1_q;
	assign mul_b = (state_q == S_MULA) ? mag_a2_q : mag_b2_q;
	assign mul_p = {{pip_pkg::COORD_W{1'b0}}, mul_a} * {{pip_pkg::COORD_W{1'b0}}, mul_b};

	// rx*|dy| < t*dx*sign(dy), signs kept apart from magnitudes
	assign na = (ma_q != '0) && neg_a_q;
	assign nb = (mb_q != '0) && neg_b_q;
	assign lt = (na != nb) ? na : (na ? (ma_q > mb_q) : (ma_q < mb_q));

	assign out_valid      = out_valid_q;
	assign inside_res     = inside_q;
	assign crossing_count = crossing_q;

	always_ff @(posedge clk) begin
		if (load_acc) begin
			mem_x[vertex_index] <= coord_x;
			mem_y[vertex_index] <= coord_y;
		end
		rdx_q <= mem_x[raddr];
		rdy_q <= mem_y[raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (query_acc) begin
					px_q   <= coord_x;
					py_q   <= coord_y;
					last_q <= last_idx;
				end
			end
			S_LAST: begin
				xj_q <= rdx_q;
				yj_q <= rdy_q;
			end
			S_EDGE: begin
				straddle_q <= (rdy_q > py_q) != (yj_q > py_q);
				is_last_q  <= (rd_idx_q == last_q);
				dy_q       <= sub33(yj_q, rdy_q);
				dx_q       <= sub33(xj_q, rdx_q);
				t_q        <= sub33(py_q, rdy_q);
				rx_q       <= sub33(px_q, rdx_q);
				xj_q       <= rdx_q;
				yj_q       <= rdy_q;
			end
			S_ABS: begin
				mag_a1_q <= mag33(rx_q);
				mag_a2_q <= mag33(dy_q);
				mag_b1_q <= mag33(t_q);
				mag_b2_q <= mag33(dx_q);
				neg_a_q  <= rx_q[pip_pkg::DIFF_W-1];
				neg_b_q  <= t_q[pip_pkg::DIFF_W-1] ^ dy_q[pip_pkg::DIFF_W-1]
					^ dx_q[pip_pkg::DIFF_W-1];
			end
			S_MULA: ma_q <= mul_p;
			S_MULB: mb_q <= mul_p;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
			crossing_q  <= '0;
		end else begin
			if (cfg_wr) begin
				vcount_q <= pwdata[pip_pkg::VCNT_W-1:0];
			end
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (query_acc) begin
						count_q  <= '0;
						rd_idx_q <= '0;
						state_q  <= (nclamp < pip_pkg::MIN_COUNT) ? S_DONE : S_LAST;
					end
				end
				S_LAST: state_q <= S_EDGE;
				S_EDGE: begin
					rd_idx_q <= rd_idx_q + pip_pkg::VIDX_W'(1);
					state_q  <= S_ABS;
				end
				S_ABS: begin
					if (straddle_q) begin
						state_q <= S_MULA;
					end else begin
						state_q <= is_last_q ? S_DONE : S_EDGE;
					end
				end
				S_MULA: state_q <= S_MULB;
				S_MULB: state_q <= S_CMP;
				S_CMP: begin
					if (lt) begin
						count_q <= count_q + pip_pkg::VCNT_W'(1);
					end
					state_q <= is_last_q ? S_DONE : S_EDGE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						inside_q    <= count_q[0];
						crossing_q  <= count_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inside_res == crossing_count[0]))
		else $error("inside_res disagrees with crossing_count parity");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (count_q <= nclamp))
		else $error("crossing count exceeds edge count");

	a_mul_straddle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MULA) |-> straddle_q)
		else $error("multiplier used on an edge that does not straddle");

	a_few_vertices: assert property (@(posedge clk) disable iff (!arst_n)
		(query_acc && (nclamp < pip_pkg::MIN_COUNT)) |=> (state_q == S_DONE && count_q == '0))
		else $error("short polygon did not finish at once");
`endif

endmodule

// ===== test/tb.sv =====
module tb;

	typedef enum int {SPAN_FULL, SPAN_TINY, SPAN_EXTREME, SPAN_MID} coord_span_t;

	typedef struct {
		logic                               op;
		logic [pip_pkg::VIDX_W-1:0]         slot;
		logic signed [pip_pkg::COORD_W-1:0] x;
		logic signed [pip_pkg::COORD_W-1:0] y;
	} poly_word_t;

	typedef struct {
		logic                       in_poly;
		logic [pip_pkg::VCNT_W-1:0] crossings;
	} verdict_t;

	localparam int SETTLE_CYCLES = 400;
	localparam int HOLD_CYCLES   = 3000;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic                               operation = pip_pkg::OP_LOAD;
	logic [pip_pkg::VIDX_W-1:0]         vertex_index = '0;
	logic signed [pip_pkg::COORD_W-1:0] coord_x = '0;
	logic signed [pip_pkg::COORD_W-1:0] coord_y = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               inside_res;
	logic [pip_pkg::VCNT_W-1:0]         crossing_count;
	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [pip_pkg::APB_AW-1:0]         paddr = '0;
	logic [pip_pkg::APB_DW-1:0]         pwdata = '0;
	logic [pip_pkg::APB_DW-1:0]         prdata;
	logic                               pready;

	point_in_polygon_test dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .vertex_index(vertex_index),
		.coord_x(coord_x), .coord_y(coord_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.inside_res(inside_res), .crossing_count(crossing_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	poly_word_t stim_words[$];
	verdict_t   pending_verdicts[$];

	// shadow of the polygon as seen by the block, updated on accepted loads
	logic signed [pip_pkg::COORD_W-1:0] vert_x [pip_pkg::MAX_VERTICES];
	logic signed [pip_pkg::COORD_W-1:0] vert_y [pip_pkg::MAX_VERTICES];
	logic [pip_pkg::VCNT_W-1:0]         poly_size_cfg = '0;

	// polygon as planned by the stimulus, used to aim query points
	logic signed [pip_pkg::COORD_W-1:0] plan_x [pip_pkg::MAX_VERTICES];
	logic signed [pip_pkg::COORD_W-1:0] plan_y [pip_pkg::MAX_VERTICES];

	int   words_pushed = 0;
	int   words_taken = 0;
	int   fault_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic in_took = 1'b0;
	logic pressure_go = 1'b0;
	logic recv_hold = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic verdict_t ray_cross_verdict(logic signed [pip_pkg::COORD_W-1:0] px,
			logic signed [pip_pkg::COORD_W-1:0] py);
		int n;
		int hits;
		int i;
		int j;
		logic signed [69:0] rx, t, dx, dy, lhs, rhs;
		verdict_t v;
		n = (int'(poly_size_cfg) > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES
			: int'(poly_size_cfg);
		hits = 0;
		if (n >= 3) begin
			for (i = 0; i < n; i++) begin
				j = (i == 0) ? n - 1 : i - 1;
				if ((vert_y[i] > py) != (vert_y[j] > py)) begin
					dy = vert_y[j] - vert_y[i];
					dx = vert_x[j] - vert_x[i];
					t  = py - vert_y[i];
					rx = px - vert_x[i];
					if (dy < 0) begin
						dy = -dy;
						t  = -t;
					end
					lhs = rx * dy;
					rhs = t * dx;
					if (lhs < rhs)
						hits++;
				end
			end
		end
		v.in_poly   = hits[0];
		v.crossings = (hits > 127) ? 7'd127 : pip_pkg::VCNT_W'(hits);
		return v;
	endfunction

	task automatic log_fault(string what);
		if (fault_count < 10)
			$display("%s", what);
		fault_count++;
	endtask

	// input side and output checking, sampled at the rising edge
	always @(posedge clk) begin : watch
		verdict_t exp_v;
		in_took = in_valid && in_ready;
		if (in_took) begin
			words_taken++;
			if (operation == pip_pkg::OP_QUERY) begin
				pending_verdicts.push_back(ray_cross_verdict(coord_x, coord_y));
			end else begin
				vert_x[vertex_index] = coord_x;
				vert_y[vertex_index] = coord_y;
			end
		end
		if (out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				log_fault($sformatf("unexpected result word inside=%0b crossings=%0d",
					inside_res, crossing_count));
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (inside_res !== exp_v.in_poly || crossing_count !== exp_v.crossings)
					log_fault($sformatf("mismatch: inside exp %0b got %0b, crossings exp %0d got %0d",
						exp_v.in_poly, inside_res, exp_v.crossings, crossing_count));
			end
		end
	end

	always @(negedge clk) begin : feed
		poly_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (stim_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				w = stim_words.pop_front();
				in_valid     <= 1'b1;
				operation    <= w.op;
				vertex_index <= w.slot;
				coord_x      <= w.x;
				coord_y      <= w.y;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// long receiver hold-off so the block backs up into the input
	initial begin
		wait (pressure_go);
		@(negedge clk);
		recv_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		recv_hold = 1'b0;
	end

	initial begin
		#15_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic write_poly_size(int value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= pip_pkg::APB_AW'(4 * int'(pip_pkg::REG_VERTEX_COUNT));
		pwdata  <= pip_pkg::APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		poly_size_cfg = pip_pkg::VCNT_W'(value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic settle();
		while (words_taken != words_pushed || pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_word(logic op, int slot, logic signed [pip_pkg::COORD_W-1:0] x,
			logic signed [pip_pkg::COORD_W-1:0] y);
		poly_word_t w;
		w.op   = op;
		w.slot = pip_pkg::VIDX_W'(slot);
		w.x    = x;
		w.y    = y;
		if (op == pip_pkg::OP_LOAD) begin
			plan_x[w.slot] = x;
			plan_y[w.slot] = y;
		end
		stim_words.push_back(w);
		words_pushed++;
	endtask

	function automatic logic signed [pip_pkg::COORD_W-1:0] rand_coord(coord_span_t span);
		logic signed [pip_pkg::COORD_W-1:0] c;
		case (span)
			SPAN_FULL: c = $urandom;
			SPAN_TINY: c = $urandom_range(32) - 16;
			SPAN_EXTREME: begin
				case ($urandom_range(5))
					0: c = 32'sh8000_0000;
					1: c = 32'sh7fff_ffff;
					2: c = 0;
					3: c = -1;
					4: c = 1;
					default: c = $urandom;
				endcase
			end
			default: c = $urandom_range(200000) - 100000;
		endcase
		return c;
	endfunction

	task automatic load_polygon(int n, coord_span_t span);
		int k;
		for (k = 0; k < n; k++)
			push_word(pip_pkg::OP_LOAD, k, rand_coord(span), rand_coord(span));
	endtask

	task automatic query_burst(int q, int n, coord_span_t span);
		int k;
		int s;
		int r;
		logic signed [pip_pkg::COORD_W:0] mid;
		for (k = 0; k < q; k++) begin
			r = $urandom_range(99);
			s = $urandom_range((n > 0) ? n - 1 : 0);
			if (r < 8) begin
				push_word(pip_pkg::OP_LOAD, $urandom_range(pip_pkg::MAX_VERTICES - 1),
					rand_coord(span), rand_coord(span));
			end else if (r < 18) begin
				push_word(pip_pkg::OP_QUERY, $urandom_range(pip_pkg::MAX_VERTICES - 1),
					plan_x[s], plan_y[s]);
			end else if (r < 32) begin
				push_word(pip_pkg::OP_QUERY, $urandom_range(pip_pkg::MAX_VERTICES - 1),
					rand_coord(span), plan_y[s]);
			end else if (r < 42) begin
				// x at the midpoint of the edge starting at vertex s, y of vertex s
				mid = (plan_x[s] + plan_x[(s + 1) % ((n > 0) ? n : 1)]) >>> 1;
				push_word(pip_pkg::OP_QUERY, $urandom_range(pip_pkg::MAX_VERTICES - 1),
					pip_pkg::COORD_W'(mid), plan_y[s]);
			end else begin
				push_word(pip_pkg::OP_QUERY, $urandom_range(pip_pkg::MAX_VERTICES - 1),
					rand_coord(span), rand_coord(span));
			end
		end
	endtask

	initial begin : run
		int phase;
		int cnt;
		int n;
		int q;
		int sizes [17];
		sizes = '{3, 4, 64, 5, 7, 127, 8, 12, 0, 6, 16, 100, 9, 2, 33, 10, 4};

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset count of zero, tiny counts, extreme triangle, edge points
		push_word(pip_pkg::OP_QUERY, 0, 0, 0);
		push_word(pip_pkg::OP_QUERY, 63, 32'sh8000_0000, 32'sh7fff_ffff);
		push_word(pip_pkg::OP_LOAD, 0, 32'sh8000_0000, 32'sh8000_0000);
		push_word(pip_pkg::OP_LOAD, 1, 32'sh7fff_ffff, 32'sh8000_0000);
		push_word(pip_pkg::OP_LOAD, 2, 0, 32'sh7fff_ffff);
		settle();
		write_poly_size(1);
		push_word(pip_pkg::OP_QUERY, 0, 0, 0);
		settle();
		write_poly_size(2);
		push_word(pip_pkg::OP_QUERY, 0, 32'sh7fff_ffff, 32'sh7fff_ffff);
		settle();
		write_poly_size(3);
		push_word(pip_pkg::OP_QUERY, 0, 0, 0);
		push_word(pip_pkg::OP_QUERY, 0, 32'sh8000_0000, 32'sh8000_0000);
		push_word(pip_pkg::OP_QUERY, 0, 32'sh7fff_ffff, 32'sh7fff_ffff);
		push_word(pip_pkg::OP_QUERY, 0, 32'sh8000_0000, 0);
		push_word(pip_pkg::OP_QUERY, 0, -1, 32'sh8000_0001);
		push_word(pip_pkg::OP_QUERY, 0, 32'sh7fff_ffff, 0);
		push_word(pip_pkg::OP_LOAD, 0, 0, 0);
		push_word(pip_pkg::OP_LOAD, 1, 10, 0);
		push_word(pip_pkg::OP_LOAD, 2, 0, 10);
		push_word(pip_pkg::OP_QUERY, 0, 1, 1);
		push_word(pip_pkg::OP_QUERY, 0, 5, 5);
		push_word(pip_pkg::OP_QUERY, 0, 0, 5);
		push_word(pip_pkg::OP_QUERY, 0, 5, 0);
		push_word(pip_pkg::OP_QUERY, 0, 0, 0);
		push_word(pip_pkg::OP_QUERY, 0, 10, 0);
		push_word(pip_pkg::OP_QUERY, 0, -1, 5);
		push_word(pip_pkg::OP_QUERY, 0, 4, 6);
		// fill every slot so no later count reads an unwritten vertex
		load_polygon(pip_pkg::MAX_VERTICES, SPAN_FULL);
		settle();

		for (phase = 0; phase < 17; phase++) begin
			cnt = sizes[phase];
			n = (cnt > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES : cnt;
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			write_poly_size(cnt);
			if (phase == 4)
				pressure_go = 1'b1;
			load_polygon(n, coord_span_t'(phase % 4));
			q = (n >= 32) ? 25 : 44;
			query_burst(q, n, coord_span_t'(phase % 4));
			settle();
		end

		if (fault_count == 0 && pending_verdicts.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
